### hdl/bf_pkg.sv
// Shared constants for the Bellman-Ford shortest path block.
`default_nettype none

package bf_pkg;

  localparam int VTX_W     = 10;
  localparam int NV_W      = 11;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_MAX_EDGES    = 4096;
  localparam int DEF_WEIGHT_BITS  = 32;
  localparam int DEF_DIST_BITS    = 48;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

  localparam logic KIND_RUN   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_VERTICES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'b1;

  localparam logic [NV_W-1:0]  NV_RESET  = 11'd1;
  localparam logic [VTX_W-1:0] SRC_RESET = 10'd0;

endpackage

`default_nettype wire

### hdl/bellman_ford_shortest_paths.sv
// Bellman-Ford single-source shortest paths over a stored edge list.
// Clear and add items finish in S_IDLE; a query reads the vertex memory, then S_QUERY
// registers the result when the output is free. A run clears all MAX_VERTICES distance
// words, writes the source, makes n passes of S_VREAD and S_RELAX per edge, then posts the result.
// The edge memory and the vertex memory (one write, two reads) set the per-edge rate.
// Reset (rst, synchronous) clears control, edge count, overflow flag and registers
// (num_vertices 1, source_vertex 0); memory contents stay undefined until written.
`default_nettype none

module bellman_ford_shortest_paths #(
  parameter int MAX_VERTICES = bf_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = bf_pkg::DEF_MAX_EDGES,
  parameter int WEIGHT_BITS  = bf_pkg::DEF_WEIGHT_BITS,
  parameter int DIST_BITS    = bf_pkg::DEF_DIST_BITS,
  localparam int IN_W  = ((3 * bf_pkg::VTX_W + WEIGHT_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((DIST_BITS + 2 + 7) / 8) * 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output      logic                         s_tready,
  // edge_tail, edge_head, edge_weight, query_vertex
  input  wire logic [IN_W-1:0]              s_tdata,
  // cmd
  input  wire logic [bf_pkg::CMD_W-1:0]     s_tuser,
  output      logic                         m_tvalid,
  input  wire logic                         m_tready,
  // distance, reachable, edges_dropped
  output      logic [OUT_W-1:0]             m_tdata,
  // kind
  output      logic [0:0]                   m_tuser,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [bf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bf_pkg::NV_W-1:0]      cfg_data
);

  localparam int VTX_W = bf_pkg::VTX_W;
  localparam int NV_W  = bf_pkg::NV_W;
  localparam int VA_W  = $clog2(MAX_VERTICES);
  localparam int EA_W  = $clog2(MAX_EDGES);
  localparam int EC_W  = $clog2(MAX_EDGES + 1);
  localparam int VX_W  = (VA_W > VTX_W) ? VA_W : VTX_W;
  localparam int SUM_W = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;

  localparam logic signed [DIST_BITS-1:0] DMAX = {1'b0, {(DIST_BITS-1){1'b1}}};
  localparam logic signed [DIST_BITS-1:0] DMIN = {1'b1, {(DIST_BITS-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX =
    {{(SUM_W-DIST_BITS+1){1'b0}}, {(DIST_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN =
    {{(SUM_W-DIST_BITS+1){1'b1}}, {(DIST_BITS-1){1'b0}}};

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_QUERY  = 3'd1;
  localparam logic [2:0] S_CLEAR  = 3'd2;
  localparam logic [2:0] S_SOURCE = 3'd3;
  localparam logic [2:0] S_VREAD  = 3'd4;
  localparam logic [2:0] S_RELAX  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  typedef struct packed {
    logic signed [WEIGHT_BITS-1:0] weight;
    logic [VTX_W-1:0]              head;
    logic [VTX_W-1:0]              tail;
  } edge_t;

  typedef struct packed {
    logic                        reach;
    logic signed [DIST_BITS-1:0] distance;
  } vword_t;

  // registers
  logic [2:0]           state;
  logic [NV_W-1:0]      num_vertices;
  logic [VTX_W-1:0]     source_vertex;
  logic [EC_W-1:0]      edge_count;
  logic                 overflow;
  logic [NV_W-1:0]      n_run;
  logic                 src_ok;
  logic                 q_ok;
  logic [VA_W-1:0]      clr_addr;
  logic [EA_W-1:0]      e_idx;
  logic [NV_W-1:0]      pass;

  // memories
  edge_t                emem [MAX_EDGES];
  vword_t               vmem [MAX_VERTICES];
  edge_t                edge_rd;
  vword_t               vrd_a;
  vword_t               vrd_b;

  // memory ports
  logic                 e_ren;
  logic [EA_W-1:0]      e_raddr;
  logic                 e_wen;
  logic                 va_ren;
  logic [VA_W-1:0]      va_addr;
  logic                 vb_ren;
  logic [VA_W-1:0]      vb_addr;
  logic                 vw_en;
  logic [VA_W-1:0]      vw_addr;
  vword_t               vw_data;

  // input decode
  logic                 in_acc;
  logic [VTX_W-1:0]     in_tail;
  logic [VTX_W-1:0]     in_head;
  logic signed [WEIGHT_BITS-1:0] in_weight;
  logic [VTX_W-1:0]     in_query;
  logic [VX_W-1:0]      q_x;
  logic [VX_W-1:0]      src_x;
  logic [VX_W-1:0]      tail_x;
  logic [VX_W-1:0]      head_x;
  logic [NV_W-1:0]      n_clamp;

  // relaxation datapath
  logic signed [DIST_BITS-1:0] d_tail;
  logic signed [DIST_BITS-1:0] d_head;
  logic signed [SUM_W-1:0]     sum;
  logic signed [DIST_BITS-1:0] cand;
  logic                        relax_ok;

  logic                 out_free;
  logic                 post;
  logic                 last_edge;
  logic                 last_pass;
  logic                 q_reach;

  assign in_acc    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign in_tail   = s_tdata[VTX_W-1:0];
  assign in_head   = s_tdata[2*VTX_W-1:VTX_W];
  assign in_weight = s_tdata[2*VTX_W+WEIGHT_BITS-1:2*VTX_W];
  assign in_query  = s_tdata[3*VTX_W+WEIGHT_BITS-1:2*VTX_W+WEIGHT_BITS];

  assign q_x    = VX_W'(in_query);
  assign src_x  = VX_W'(source_vertex);
  assign tail_x = VX_W'(edge_rd.tail);
  assign head_x = VX_W'(edge_rd.head);

  always_comb begin
    if (num_vertices == '0) begin
      n_clamp = NV_W'(1);
    end else if (int'(num_vertices) > MAX_VERTICES) begin
      n_clamp = NV_W'(MAX_VERTICES);
    end else begin
      n_clamp = num_vertices;
    end
  end

  assign d_tail = vrd_a.distance;
  assign d_head = vrd_b.distance;
  assign sum = {{(SUM_W-DIST_BITS){d_tail[DIST_BITS-1]}}, d_tail}
             + {{(SUM_W-WEIGHT_BITS){edge_rd.weight[WEIGHT_BITS-1]}}, edge_rd.weight};

  always_comb begin
    if (sum > SUM_MAX) begin
      cand = DMAX;
    end else if (sum < SUM_MIN) begin
      cand = DMIN;
    end else begin
      cand = sum[DIST_BITS-1:0];
    end
  end

  assign relax_ok = ({1'b0, edge_rd.tail} < n_run) && ({1'b0, edge_rd.head} < n_run)
                 && vrd_a.reach && (!vrd_b.reach || (cand < d_head));

  assign last_edge = (EC_W'(e_idx) + EC_W'(1)) == edge_count;
  assign last_pass = (pass + NV_W'(1)) == n_run;
  assign out_free  = !m_tvalid || m_tready;
  assign post      = out_free && ((state == S_QUERY) || (state == S_FINISH));
  assign q_reach   = q_ok && vrd_a.reach;

  always_comb begin
    e_ren   = 1'b0;
    e_raddr = '0;
    e_wen   = in_acc && (s_tuser == bf_pkg::CMD_ADD) && (edge_count < EC_W'(MAX_EDGES));
    va_ren  = 1'b0;
    va_addr = tail_x[VA_W-1:0];
    vb_ren  = 1'b0;
    vb_addr = head_x[VA_W-1:0];
    vw_en   = 1'b0;
    vw_addr = clr_addr;
    vw_data = '{reach: 1'b0, distance: DMAX};
    case (state)
      S_IDLE: begin
        if (in_acc && (s_tuser == bf_pkg::CMD_QUERY)) begin
          va_ren  = 1'b1;
          va_addr = q_x[VA_W-1:0];
        end
      end
      S_CLEAR: begin
        vw_en = 1'b1;
      end
      S_SOURCE: begin
        vw_en   = src_ok;
        vw_addr = src_x[VA_W-1:0];
        vw_data = '{reach: 1'b1, distance: '0};
        e_ren   = 1'b1;
      end
      S_VREAD: begin
        va_ren = 1'b1;
        vb_ren = 1'b1;
      end
      S_RELAX: begin
        vw_en   = relax_ok;
        vw_addr = head_x[VA_W-1:0];
        vw_data = '{reach: 1'b1, distance: cand};
        e_ren   = !(last_edge && last_pass);
        e_raddr = last_edge ? '0 : e_idx + EA_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (e_wen) begin
      emem[edge_count[EA_W-1:0]] <= '{tail: in_tail, head: in_head, weight: in_weight};
    end
    if (e_ren) begin
      edge_rd <= emem[e_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (vw_en) begin
      vmem[vw_addr] <= vw_data;
    end
    if (va_ren) begin
      vrd_a <= vmem[va_addr];
    end
    if (vb_ren) begin
      vrd_b <= vmem[vb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vertices  <= bf_pkg::NV_RESET;
      source_vertex <= bf_pkg::SRC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bf_pkg::REG_NUM_VERTICES:  num_vertices  <= cfg_data;
        bf_pkg::REG_SOURCE_VERTEX: source_vertex <= cfg_data[VTX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      edge_count <= '0;
      overflow   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (post) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (s_tuser)
              bf_pkg::CMD_CLEAR: begin
                edge_count <= '0;
                overflow   <= 1'b0;
              end
              bf_pkg::CMD_ADD: begin
                if (e_wen) begin
                  edge_count <= edge_count + EC_W'(1);
                end else begin
                  overflow <= 1'b1;
                end
              end
              bf_pkg::CMD_RUN: begin
                n_run    <= n_clamp;
                src_ok   <= {1'b0, source_vertex} < n_clamp;
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              default: begin
                q_ok  <= int'(in_query) < MAX_VERTICES;
                state <= S_QUERY;
              end
            endcase
          end
        end
        S_QUERY: begin
          if (out_free) begin
            m_tuser  <= bf_pkg::KIND_QUERY;
            m_tdata  <= OUT_W'({overflow, q_reach, q_reach ? vrd_a.distance : DMAX});
            state    <= S_IDLE;
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + VA_W'(1);
          if (clr_addr == VA_W'(MAX_VERTICES - 1)) begin
            state <= S_SOURCE;
          end
        end
        S_SOURCE: begin
          e_idx <= '0;
          pass  <= '0;
          state <= (edge_count == '0) ? S_FINISH : S_VREAD;
        end
        S_VREAD: begin
          state <= S_RELAX;
        end
        S_RELAX: begin
          if (last_edge) begin
            e_idx <= '0;
            pass  <= pass + NV_W'(1);
            state <= last_pass ? S_FINISH : S_VREAD;
          end else begin
            e_idx <= e_idx + EA_W'(1);
            state <= S_VREAD;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            m_tuser  <= bf_pkg::KIND_RUN;
            m_tdata  <= OUT_W'({overflow, 1'b0, {DIST_BITS{1'b0}}});
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_edge_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(edge_count) <= MAX_EDGES)
    else $error("edge count above capacity");

  a_clear_effect: assert property (@(posedge clk) disable iff (rst)
    in_acc && (s_tuser == bf_pkg::CMD_CLEAR) |=> (edge_count == '0) && !overflow)
    else $error("clear item did not empty the edge store");

  a_run_result_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] == bf_pkg::KIND_RUN) |-> (m_tdata[DIST_BITS:0] == '0))
    else $error("run result carries distance or reachable bits");

  a_relax_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_RELAX) |-> (pass < n_run) && (EC_W'(e_idx) < edge_count))
    else $error("relaxation index out of range");

endmodule

`default_nettype wire

### test/bellman_ford_shortest_paths_tb.sv
// Testbench for bellman_ford_shortest_paths: directed and random graphs checked against a predictor.
`timescale 1ns / 1ps

module bellman_ford_shortest_paths_tb;

  localparam int VTX_W = bf_pkg::VTX_W;
  localparam int NV_W = bf_pkg::NV_W;
  localparam int CMD_W = bf_pkg::CMD_W;
  localparam int CFG_IDX_W = bf_pkg::CFG_IDX_W;
  localparam int IN_W = 64;
  localparam int OUT_W = 56;
  localparam int NUM_VTX = bf_pkg::DEF_MAX_VERTICES;
  localparam int NUM_EDGES = bf_pkg::DEF_MAX_EDGES;
  localparam int DW = bf_pkg::DEF_DIST_BITS;
  localparam int WW = bf_pkg::DEF_WEIGHT_BITS;
  localparam longint DIST_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint DIST_MIN = -DIST_MAX - 1;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int RANDOM_ITEMS = 700;

  typedef struct {
    logic kind;
    logic signed [DW-1:0] distance;
    logic reachable;
    logic dropped;
  } answer_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_W-1:0] s_tdata;   // edge_tail, edge_head, edge_weight, query_vertex
  logic [CMD_W-1:0] s_tuser;  // cmd
  logic m_tvalid;
  logic m_tready;
  logic [OUT_W-1:0] m_tdata;  // distance, reachable, edges_dropped
  logic [0:0] m_tuser;        // kind
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [NV_W-1:0] cfg_data;

  answer_t pending_answers[$];

  logic [VTX_W-1:0] stored_tail [NUM_EDGES];
  logic [VTX_W-1:0] stored_head [NUM_EDGES];
  longint stored_weight [NUM_EDGES];
  int stored_count = 0;
  logic store_overflow = 1'b0;
  longint vtx_dist [NUM_VTX];
  logic vtx_reached [NUM_VTX];
  logic [NV_W-1:0] nv_setting = bf_pkg::NV_RESET;
  logic [VTX_W-1:0] src_setting = bf_pkg::SRC_RESET;

  int items_sent = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int hold_cycles = 0;
  bit steady = 1'b0;

  bellman_ford_shortest_paths uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL bellman_ford_shortest_paths");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Predictor: updates the edge store and distances, queues the answer if any.
  task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [VTX_W-1:0] tail,
                               input logic [VTX_W-1:0] head,
                               input logic signed [WW-1:0] w,
                               input logic [VTX_W-1:0] qv);
    answer_t a;
    int n;
    int t;
    int h;
    int p;
    int e;
    int v;
    longint cand;
    longint d;
    a.kind = bf_pkg::KIND_RUN;
    a.distance = '0;
    a.reachable = 1'b0;
    a.dropped = store_overflow;
    case (cmd)
      bf_pkg::CMD_CLEAR: begin
        stored_count = 0;
        store_overflow = 1'b0;
      end
      bf_pkg::CMD_ADD: begin
        if (stored_count < NUM_EDGES) begin
          stored_tail[stored_count] = tail;
          stored_head[stored_count] = head;
          stored_weight[stored_count] = w;
          stored_count++;
        end else begin
          store_overflow = 1'b1;
        end
      end
      bf_pkg::CMD_RUN: begin
        n = nv_setting;
        if (n == 0) n = 1;
        if (n > NUM_VTX) n = NUM_VTX;
        for (v = 0; v < NUM_VTX; v++) begin
          vtx_reached[v] = 1'b0;
          vtx_dist[v] = DIST_MAX;
        end
        if (src_setting < n) begin
          vtx_dist[src_setting] = 0;
          vtx_reached[src_setting] = 1'b1;
        end
        for (p = 0; p < n; p++) begin
          for (e = 0; e < stored_count; e++) begin
            t = stored_tail[e];
            h = stored_head[e];
            if (t < n && h < n && vtx_reached[t]) begin
              cand = vtx_dist[t] + stored_weight[e];
              if (cand > DIST_MAX) cand = DIST_MAX;
              if (cand < DIST_MIN) cand = DIST_MIN;
              if (!vtx_reached[h] || cand < vtx_dist[h]) begin
                vtx_dist[h] = cand;
                vtx_reached[h] = 1'b1;
              end
            end
          end
        end
        a.dropped = store_overflow;
        pending_answers = {pending_answers, a};
      end
      bf_pkg::CMD_QUERY: begin
        d = vtx_reached[qv] ? vtx_dist[qv] : DIST_MAX;
        a.kind = bf_pkg::KIND_QUERY;
        a.reachable = vtx_reached[qv];
        a.distance = d[DW-1:0];
        pending_answers = {pending_answers, a};
      end
    endcase
  endtask

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VTX_W-1:0] tail,
                           input logic [VTX_W-1:0] head,
                           input logic signed [WW-1:0] w,
                           input logic [VTX_W-1:0] qv);
    if (!steady && $urandom_range(99) < 19) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {2'b00, qv, w, head, tail};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_command(cmd, tail, head, w, qv);
    items_sent++;
  endtask

  task automatic clear_edges();
    send_item(bf_pkg::CMD_CLEAR, '0, '0, '0, '0);
  endtask

  task automatic add_edge(input logic [VTX_W-1:0] tail, input logic [VTX_W-1:0] head,
                          input logic signed [WW-1:0] w);
    send_item(bf_pkg::CMD_ADD, tail, head, w, '0);
  endtask

  task automatic run_graph();
    send_item(bf_pkg::CMD_RUN, '0, '0, '0, '0);
  endtask

  task automatic query(input logic [VTX_W-1:0] v);
    send_item(bf_pkg::CMD_QUERY, '0, '0, '0, v);
  endtask

  // Clear and add items produce no result, hence the short pad.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [NV_W-1:0] nv, input logic [VTX_W-1:0] src);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= bf_pkg::REG_NUM_VERTICES;
    cfg_data <= nv;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    nv_setting = nv;
    cfg_index <= bf_pkg::REG_SOURCE_VERTEX;
    cfg_data <= {1'b0, src};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    src_setting = src;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VTX_W-1:0] pick_vertex(input int n);
    int v;
    if ($urandom_range(99) < 15) return VTX_W'($urandom);
    v = $urandom_range(0, n);
    return (v > NUM_VTX - 1) ? VTX_W'(NUM_VTX - 1) : VTX_W'(v);
  endfunction

  function automatic logic signed [WW-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else if (steady) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 19);
    end
  end

  always @(posedge clk) begin : check_answers
    answer_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result item with no answer pending");
      end else begin
        want = pending_answers.pop_front();
        if (m_tuser[0] !== want.kind)
          report_mismatch($sformatf("kind got %0d want %0d", m_tuser[0], want.kind));
        if (m_tdata[DW-1:0] !== want.distance)
          report_mismatch($sformatf("distance got %0d want %0d",
                                    $signed(m_tdata[DW-1:0]), want.distance));
        if (m_tdata[DW] !== want.reachable)
          report_mismatch($sformatf("reachable got %0d want %0d", m_tdata[DW],
                                    want.reachable));
        if (m_tdata[DW+1] !== want.dropped)
          report_mismatch($sformatf("edges_dropped got %0d want %0d", m_tdata[DW+1],
                                    want.dropped));
      end
    end
  end

  task automatic test_small_graph();
    set_config(11'd5, 10'd0);
    clear_edges();
    add_edge(10'd0, 10'd1, 32'sd7);
    add_edge(10'd1, 10'd2, -32'sd3);
    add_edge(10'd0, 10'd2, 32'sd10);
    add_edge(10'd2, 10'd3, 32'sh7FFF_FFFF);
    add_edge(10'd3, 10'd4, 32'sh8000_0000);
    add_edge(10'd6, 10'd1, -32'sd100);   // tail outside vertex count
    add_edge(10'd1, 10'd1023, 32'sd1);   // head outside vertex count
    run_graph();
    query(10'd0);
    query(10'd1);
    query(10'd2);
    query(10'd3);
    query(10'd4);
    query(10'd5);
    query(10'd1023);
  endtask

  task automatic test_register_extremes();
    set_config(11'd0, 10'd0);            // zero vertices acts as one
    run_graph();
    query(10'd0);
    query(10'd1);
    set_config(11'd2047, 10'd1023);      // clamps to the full vertex range
    clear_edges();
    add_edge(10'd1023, 10'd0, -32'sd5);
    add_edge(10'd0, 10'd512, 32'sd3);
    run_graph();
    query(10'd1023);
    query(10'd0);
    query(10'd512);
    query(10'd511);
    set_config(11'd3, 10'd7);            // source beyond vertex count
    run_graph();
    query(10'd7);
    query(10'd0);
  endtask

  task automatic test_saturation();
    set_config(11'd1024, 10'd0);
    clear_edges();
    repeat (80) add_edge(10'd0, 10'd0, 32'sh8000_0000);
    add_edge(10'd0, 10'd1, 32'sh7FFF_FFFF);
    run_graph();
    query(10'd0);
    query(10'd1);
  endtask

  task automatic test_store_full();
    steady = 1'b1;
    set_config(11'd2, 10'd0);
    clear_edges();
    repeat (NUM_EDGES + 1)
      add_edge(VTX_W'($urandom_range(0, 1)), VTX_W'($urandom_range(0, 1)),
               $signed($urandom_range(0, 200)) - 100);
    run_graph();
    query(10'd0);
    query(10'd1);
    add_edge(10'd0, 10'd1, 32'sd1);
    query(10'd1);
    clear_edges();
    run_graph();
    query(10'd0);
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    set_config(11'd4, 10'd0);
    clear_edges();
    add_edge(10'd0, 10'd1, 32'sd5);
    add_edge(10'd1, 10'd2, 32'sd5);
    run_graph();
    wait_idle();
    hold_cycles = 300;
    repeat (24) query(VTX_W'($urandom_range(0, 3)));
    wait_idle();
  endtask

  task automatic test_random_graphs();
    int target;
    int phase;
    int k;
    int n_eff;
    bit wide;
    logic [NV_W-1:0] nv;
    logic [VTX_W-1:0] src;
    target = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < target) begin
      wide = ($urandom_range(99) < 8);
      if (wide) begin
        case ($urandom_range(0, 3))
          0: nv = 11'd0;
          1: nv = 11'd1024;
          2: nv = 11'd2047;
          default: nv = NV_W'($urandom_range(1025, 2047));
        endcase
      end else begin
        nv = NV_W'($urandom_range(1, 16));
      end
      n_eff = (nv == 0) ? 1 : ((nv > NUM_VTX) ? NUM_VTX : nv);
      src = ($urandom_range(9) == 0) ? VTX_W'($urandom) : pick_vertex(n_eff);
      set_config(nv, src);
      steady = (phase >= 4 && phase < 8);
      if (wide || stored_count > 40 || $urandom_range(2) == 0) clear_edges();
      k = wide ? $urandom_range(0, 6) : $urandom_range(0, 20);
      repeat (k) begin
        if ($urandom_range(9) == 0)
          send_item(CMD_W'($urandom), VTX_W'($urandom), VTX_W'($urandom), $urandom,
                    VTX_W'($urandom));
        else
          add_edge(pick_vertex(n_eff), pick_vertex(n_eff), pick_weight());
      end
      run_graph();
      repeat ($urandom_range(2, 8)) query(pick_vertex(n_eff));
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 4)) add_edge(pick_vertex(n_eff), pick_vertex(n_eff),
                                               pick_weight());
        run_graph();
        repeat (2) query(pick_vertex(n_eff));
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = bf_pkg::CMD_CLEAR;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = bf_pkg::REG_NUM_VERTICES;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_small_graph();
    test_register_extremes();
    test_saturation();
    test_store_full();
    test_backpressure();
    test_random_graphs();
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS bellman_ford_shortest_paths");
    end else begin
      $display("FAIL bellman_ford_shortest_paths");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/bf_pkg.sv
hdl/bellman_ford_shortest_paths.sv
test/bellman_ford_shortest_paths_tb.sv
